/* rtl/rsm_pkg.sv */
`default_nettype none

package rsm_pkg;

	// Mixing modes as held in the mix_mode register
	typedef enum logic [1:0] {
		MODE_STEREO  = 2'd0,
		MODE_MONO    = 2'd1,
		MODE_DOPPLER = 2'd2,
		MODE_CROSS   = 2'd3
	} mix_mode_t;

	// Configuration register indexes
	localparam int          REG_IW        = 3;
	localparam logic [2:0]  REG_MIX_MODE  = 3'd0;
	localparam logic [2:0]  REG_GAIN_L    = 3'd1;
	localparam logic [2:0]  REG_GAIN_R    = 3'd2;
	localparam logic [2:0]  REG_GAIN2_L   = 3'd3;
	localparam logic [2:0]  REG_GAIN2_R   = 3'd4;
	localparam logic [2:0]  REG_RATE_STEP = 3'd5;
	localparam logic [2:0]  REG_WEIGHT_1  = 3'd6;
	localparam logic [2:0]  REG_WEIGHT_2  = 3'd7;

	localparam logic [31:0] RATE_STEP_RST = 32'd268435456;
	localparam logic [8:0]  WEIGHT_1_RST  = 9'd256;

	// Queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = 1;
	localparam int Q_CW    = 2;

	typedef struct packed {
		logic signed [15:0] src_left;
		logic signed [15:0] src_right;
		logic signed [31:0] acc_left;
		logic signed [31:0] acc_right;
		logic [3:0]         adv;
	} rsm_entry_t;

	typedef struct packed {
		logic            full;
		logic            empty;
		logic [Q_CW-1:0] count;
	} rsm_qstat_t;

	typedef struct packed {
		mix_mode_t  mode;
		logic [7:0] gain_left;
		logic [7:0] gain_right;
		logic [7:0] gain2_left;
		logic [7:0] gain2_right;
		logic [8:0] weight_first;
		logic [8:0] weight_second;
	} rsm_mix_cfg_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_PRE  = 2'd1,
		BK_MUL  = 2'd2,
		BK_ADD  = 2'd3
	} rsm_bk_state_t;

	typedef struct packed {
		logic pop;
		logic ld_op;
		logic ld_term;
		logic ld_out;
	} rsm_bk_ctrl_t;

endpackage

`default_nettype wire

/* rtl/rsm_front.sv */
`default_nettype none

module rsm_front #(
	parameter int FRAC_BITS = 28
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] src_left,
	input  wire logic signed [15:0] src_right,
	input  wire logic signed [31:0] acc_left_in,
	input  wire logic signed [31:0] acc_right_in,
	input  wire logic               run_start,
	input  wire logic [31:0]        start_phase,
	input  wire logic [31:0]        rate_step,
	input  wire logic               q_full,
	output logic                    q_push,
	output rsm_pkg::rsm_entry_t     q_data
);

	logic [FRAC_BITS-1:0] phase_q;
	logic [31:0]          base;
	logic [31:0]          sum;
	logic [31:0]          adv_full;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	// Phase advances in transfer order, so the fraction is settled here
	assign base     = run_start ? start_phase : {{(32-FRAC_BITS){1'b0}}, phase_q};
	assign sum      = base + rate_step;
	assign adv_full = sum >> FRAC_BITS;

	always_comb begin
		q_data.src_left  = src_left;
		q_data.src_right = src_right;
		q_data.acc_left  = acc_left_in;
		q_data.acc_right = acc_right_in;
		q_data.adv       = (adv_full > 32'd15) ? 4'd15 : adv_full[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (q_push) begin
			phase_q <= sum[FRAC_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

/* rtl/rsm_fifo.sv */
`default_nettype none

module rsm_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire rsm_pkg::rsm_entry_t  push_data,
	input  wire logic                 pop,
	output rsm_pkg::rsm_entry_t       head,
	output rsm_pkg::rsm_qstat_t       stat
);

	rsm_pkg::rsm_entry_t          mem_q [rsm_pkg::Q_DEPTH];
	logic [rsm_pkg::Q_AW-1:0]     wr_ptr_q;
	logic [rsm_pkg::Q_AW-1:0]     rd_ptr_q;
	logic [rsm_pkg::Q_CW-1:0]     count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.full  = (count_q == rsm_pkg::Q_CW'(rsm_pkg::Q_DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= rsm_pkg::Q_AW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= rsm_pkg::Q_AW'(rd_ptr_q + 1'b1);
			end
			count_q <= count_q + rsm_pkg::Q_CW'(push) - rsm_pkg::Q_CW'(pop);
		end
	end

endmodule

`default_nettype wire

/* rtl/rsm_back.sv */
`default_nettype none

module rsm_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rsm_pkg::rsm_mix_cfg_t cfg,
	input  wire rsm_pkg::rsm_entry_t  head,
	input  wire logic                 q_empty,
	output logic                      q_pop,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [31:0]        acc_left_out,
	output logic signed [31:0]        acc_right_out,
	output logic [3:0]                frames_advance
);

	rsm_pkg::rsm_bk_state_t state_q;
	rsm_pkg::rsm_bk_state_t state_nxt;
	rsm_pkg::rsm_bk_ctrl_t  ctrl;

	rsm_pkg::rsm_entry_t    work_q;
	logic signed [17:0]     opl_q;
	logic signed [17:0]     opr_q;
	logic signed [18:0]     tl1_q;
	logic signed [18:0]     tr1_q;
	logic signed [16:0]     tl2_q;
	logic signed [16:0]     tr2_q;
	logic                   out_valid_q;
	logic signed [31:0]     acc_l_q;
	logic signed [31:0]     acc_r_q;
	logic [3:0]             adv_q;

	logic                   out_free;
	logic signed [25:0]     pf;
	logic signed [25:0]     ps;
	logic signed [17:0]     xf;
	logic signed [17:0]     sl;
	logic signed [17:0]     sr;
	logic signed [26:0]     pl1;
	logic signed [26:0]     pr1;
	logic signed [24:0]     pl2;
	logic signed [24:0]     pr2;

	assign out_free = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rsm_pkg::BK_IDLE: begin
				if (!q_empty) begin
					state_nxt = rsm_pkg::BK_PRE;
				end
			end
			rsm_pkg::BK_PRE: state_nxt = rsm_pkg::BK_MUL;
			rsm_pkg::BK_MUL: state_nxt = rsm_pkg::BK_ADD;
			rsm_pkg::BK_ADD: begin
				if (out_free) begin
					state_nxt = rsm_pkg::BK_IDLE;
				end
			end
			default: state_nxt = rsm_pkg::BK_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		ctrl = '0;
		case (state_q)
			rsm_pkg::BK_IDLE: ctrl.pop     = !q_empty;
			rsm_pkg::BK_PRE:  ctrl.ld_op   = 1'b1;
			rsm_pkg::BK_MUL:  ctrl.ld_term = 1'b1;
			rsm_pkg::BK_ADD:  ctrl.ld_out  = out_free;
			default:          ctrl = '0;
		endcase
	end

	assign q_pop = ctrl.pop;

	// Crossfade pre-mix and operand choice
	assign pf = $signed({{10{work_q.src_left[15]}}, work_q.src_left})
		* $signed({17'd0, cfg.weight_first});
	assign ps = $signed({{10{work_q.src_right[15]}}, work_q.src_right})
		* $signed({17'd0, cfg.weight_second});
	assign xf = $signed(pf[25:8]) + $signed(ps[25:8]);
	assign sl = {{2{work_q.src_left[15]}}, work_q.src_left};
	assign sr = {{2{work_q.src_right[15]}}, work_q.src_right};

	// Gain products on the registered operands
	assign pl1 = $signed({19'd0, cfg.gain_left}) * $signed({{9{opl_q[17]}}, opl_q});
	assign pr1 = $signed({19'd0, cfg.gain_right}) * $signed({{9{opr_q[17]}}, opr_q});
	assign pl2 = $signed({17'd0, cfg.gain2_left})
		* $signed({{9{work_q.src_right[15]}}, work_q.src_right});
	assign pr2 = $signed({17'd0, cfg.gain2_right})
		* $signed({{9{work_q.src_right[15]}}, work_q.src_right});

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			work_q <= head;
		end
		if (ctrl.ld_op) begin
			case (cfg.mode)
				rsm_pkg::MODE_STEREO: begin
					opl_q <= sl;
					opr_q <= sr;
				end
				rsm_pkg::MODE_MONO, rsm_pkg::MODE_DOPPLER: begin
					opl_q <= sl;
					opr_q <= sl;
				end
				default: begin
					opl_q <= xf;
					opr_q <= xf;
				end
			endcase
		end
		if (ctrl.ld_term) begin
			tl1_q <= $signed(pl1[26:8]);
			tr1_q <= $signed(pr1[26:8]);
			if (cfg.mode == rsm_pkg::MODE_DOPPLER) begin
				tl2_q <= $signed(pl2[24:8]);
				tr2_q <= $signed(pr2[24:8]);
			end else begin
				tl2_q <= '0;
				tr2_q <= '0;
			end
		end
		if (ctrl.ld_out) begin
			acc_l_q <= work_q.acc_left + {{13{tl1_q[18]}}, tl1_q}
				+ {{15{tl2_q[16]}}, tl2_q};
			acc_r_q <= work_q.acc_right + {{13{tr1_q[18]}}, tr1_q}
				+ {{15{tr2_q[16]}}, tr2_q};
			adv_q   <= work_q.adv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rsm_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctrl.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign acc_left_out   = acc_l_q;
	assign acc_right_out  = acc_r_q;
	assign frames_advance = adv_q;

endmodule

`default_nettype wire

/* rtl/resampling_stereo_channel_mixer_unit.sv */
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    src_left, src_right, acc_left_in,
//                                             acc_right_in, run_start, start_phase
// out       output     out_valid / out_ready  acc_left_out, acc_right_out,
//                                             frames_advance
// cfg       input      cfg_wr_en              cfg_index, cfg_wdata
//
// The back-end sequencer walks each item through pop, pre-mix, gain multiply and
// accumulate steps on one set of multipliers, and pops the next item only after the
// last result is loaded into the output register, which waits while out is stalled.
// The front end settles the phase at transfer and parks items in a two-entry queue,
// so input keeps flowing while a finished result waits at the output register.
// Reset is asynchronous and active low; it clears the phase, queue, sequencer and
// configuration registers to their defaults.
`default_nettype none

module resampling_stereo_channel_mixer_unit #(
	parameter int FRAC_BITS = 28
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] src_left,
	input  wire logic signed [15:0] src_right,
	input  wire logic signed [31:0] acc_left_in,
	input  wire logic signed [31:0] acc_right_in,
	input  wire logic               run_start,
	input  wire logic [31:0]        start_phase,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      acc_left_out,
	output logic signed [31:0]      acc_right_out,
	output logic [3:0]              frames_advance,
	input  wire logic               cfg_wr_en,
	input  wire logic [rsm_pkg::REG_IW-1:0] cfg_index,
	input  wire logic [31:0]        cfg_wdata
);

	rsm_pkg::rsm_mix_cfg_t cfg_q;
	logic [31:0]           rate_step_q;

	rsm_pkg::rsm_entry_t   q_in;
	rsm_pkg::rsm_entry_t   q_head;
	rsm_pkg::rsm_qstat_t   q_stat;
	logic                  q_push;
	logic                  q_pop;

	// Configuration registers; the user must write them only while the block is idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode          <= rsm_pkg::MODE_STEREO;
			cfg_q.gain_left     <= '0;
			cfg_q.gain_right    <= '0;
			cfg_q.gain2_left    <= '0;
			cfg_q.gain2_right   <= '0;
			cfg_q.weight_first  <= rsm_pkg::WEIGHT_1_RST;
			cfg_q.weight_second <= '0;
			rate_step_q         <= rsm_pkg::RATE_STEP_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				rsm_pkg::REG_MIX_MODE:  cfg_q.mode <= rsm_pkg::mix_mode_t'(cfg_wdata[1:0]);
				rsm_pkg::REG_GAIN_L:    cfg_q.gain_left     <= cfg_wdata[7:0];
				rsm_pkg::REG_GAIN_R:    cfg_q.gain_right    <= cfg_wdata[7:0];
				rsm_pkg::REG_GAIN2_L:   cfg_q.gain2_left    <= cfg_wdata[7:0];
				rsm_pkg::REG_GAIN2_R:   cfg_q.gain2_right   <= cfg_wdata[7:0];
				rsm_pkg::REG_RATE_STEP: rate_step_q         <= cfg_wdata;
				rsm_pkg::REG_WEIGHT_1:  cfg_q.weight_first  <= cfg_wdata[8:0];
				rsm_pkg::REG_WEIGHT_2:  cfg_q.weight_second <= cfg_wdata[8:0];
				default: begin
				end
			endcase
		end
	end

	// Front end: take the transfer, advance the phase, queue the item
	rsm_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.src_left     (src_left),
		.src_right    (src_right),
		.acc_left_in  (acc_left_in),
		.acc_right_in (acc_right_in),
		.run_start    (run_start),
		.start_phase  (start_phase),
		.rate_step    (rate_step_q),
		.q_full       (q_stat.full),
		.q_push       (q_push),
		.q_data       (q_in)
	);

	// Hold items between the two halves
	rsm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	// Back end: mix into the accumulators and drive the result register
	rsm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.head           (q_head),
		.q_empty        (q_stat.empty),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.acc_left_out   (acc_left_out),
		.acc_right_out  (acc_right_out),
		.frames_advance (frames_advance)
	);

	// Never push into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("push into full queue");

	// Never pop an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	// Fill level tracks pushes and pops exactly
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(!arst_n) |=> q_stat.count == $past(q_stat.count)
			+ rsm_pkg::Q_CW'($past(q_push)) - rsm_pkg::Q_CW'($past(q_pop)))
		else $error("queue fill level out of step");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import rsm_pkg::*;

	localparam int FRAC_BITS   = 28;
	// Cycles without any transfer, while work is outstanding, before giving up
	localparam int STALL_LIMIT = 2000;

	// One source frame plus the paint accumulators of its output slot
	typedef struct packed {
		logic signed [15:0] src_left;
		logic signed [15:0] src_right;
		logic signed [31:0] acc_left;
		logic signed [31:0] acc_right;
		logic               run_start;
		logic [31:0]        start_phase;
	} frame_t;

	// Updated accumulators and the source advance for one slot
	typedef struct packed {
		logic signed [31:0] acc_left;
		logic signed [31:0] acc_right;
		logic [3:0]         advance;
	} slot_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Every input starts known; reset holds them until the block is out of reset
	logic                           in_valid     = 1'b0;
	logic                           in_ready;
	logic signed [15:0]             src_left     = '0;
	logic signed [15:0]             src_right    = '0;
	logic signed [31:0]             acc_left_in  = '0;
	logic signed [31:0]             acc_right_in = '0;
	logic                           run_start    = 1'b0;
	logic [31:0]                    start_phase  = '0;
	logic                           out_valid;
	logic                           out_ready    = 1'b0;
	logic signed [31:0]             acc_left_out;
	logic signed [31:0]             acc_right_out;
	logic [3:0]                     frames_advance;
	logic                           cfg_wr_en    = 1'b0;
	logic [REG_IW-1:0]              cfg_index    = '0;
	logic [31:0]                    cfg_wdata    = '0;

	// Shadow of the register file and the phase loop, kept in step with the block
	rsm_mix_cfg_t         mix_cfg = '{MODE_STEREO, 8'd0, 8'd0, 8'd0, 8'd0, WEIGHT_1_RST, 9'd0};
	logic [31:0]          rate_step_r = RATE_STEP_RST;
	logic [FRAC_BITS-1:0] phase_frac  = '0;

	frame_t frames_q[$];     // frames waiting to be offered to the block
	slot_t  mixed_q[$];      // predicted slots, oldest first

	frame_t drv_frame;
	int     in_gap      = 0;
	int     out_gap     = 0;
	bit     allow_idle  = 1'b1;
	int     fail_count  = 0;
	int     n_frames    = 0;
	int     n_checked   = 0;
	int     n_settings  = 0;
	int     stall_count = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	resampling_stereo_channel_mixer_unit #(
		.FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.src_left      (src_left),
		.src_right     (src_right),
		.acc_left_in   (acc_left_in),
		.acc_right_in  (acc_right_in),
		.run_start     (run_start),
		.start_phase   (start_phase),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.acc_left_out  (acc_left_out),
		.acc_right_out (acc_right_out),
		.frames_advance(frames_advance),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	// Add a contribution to a 32-bit accumulator, wrapping modulo 2^32
	function automatic logic [31:0] wrap_add(input logic [31:0] acc, input longint contrib);
		return acc + contrib[31:0];
	endfunction

	// Mix one frame into its slot and advance the phase loop.
	// Shifts on longint are arithmetic, so >>> 8 floors negative products.
	function automatic slot_t mix_slot(input frame_t f);
		longint      l, r, gl, gr, g2l, g2r, w1, w2, x;
		logic [31:0] base, sum, whole;
		slot_t       res;
		l   = longint'(f.src_left);
		r   = longint'(f.src_right);
		gl  = longint'(mix_cfg.gain_left);
		gr  = longint'(mix_cfg.gain_right);
		g2l = longint'(mix_cfg.gain2_left);
		g2r = longint'(mix_cfg.gain2_right);
		w1  = longint'(mix_cfg.weight_first);
		w2  = longint'(mix_cfg.weight_second);
		res.acc_left  = f.acc_left;
		res.acc_right = f.acc_right;
		case (mix_cfg.mode)
			MODE_STEREO: begin
				res.acc_left  = wrap_add(res.acc_left, (gl * l) >>> 8);
				res.acc_right = wrap_add(res.acc_right, (gr * r) >>> 8);
			end
			MODE_MONO: begin
				res.acc_left  = wrap_add(res.acc_left, (gl * l) >>> 8);
				res.acc_right = wrap_add(res.acc_right, (gr * l) >>> 8);
			end
			MODE_DOPPLER: begin
				// first pair on the left sample, second pair on the right one
				res.acc_left  = wrap_add(res.acc_left, (gl * l) >>> 8);
				res.acc_right = wrap_add(res.acc_right, (gr * l) >>> 8);
				res.acc_left  = wrap_add(res.acc_left, (g2l * r) >>> 8);
				res.acc_right = wrap_add(res.acc_right, (g2r * r) >>> 8);
			end
			MODE_CROSS: begin
				// weights above unity pass through unclamped
				x = ((l * w1) >>> 8) + ((r * w2) >>> 8);
				res.acc_left  = wrap_add(res.acc_left, (gl * x) >>> 8);
				res.acc_right = wrap_add(res.acc_right, (gr * x) >>> 8);
			end
		endcase
		// A run start takes the whole start phase, integer bits included
		if (f.run_start) begin
			base = f.start_phase;
		end else begin
			base = 32'(phase_frac);
		end
		sum   = base + rate_step_r;
		whole = sum >> FRAC_BITS;
		res.advance = (whole > 32'd15) ? 4'd15 : whole[3:0];
		phase_frac  = sum[FRAC_BITS-1:0];
		return res;
	endfunction

	// Input driver: offer queued frames, insert random idle bursts, predict on transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				mixed_q.push_back(mix_slot(drv_frame));
				n_frames++;
			end
			// Advance only when nothing is held, or the held frame just transferred
			if (!in_valid || in_ready) begin
				if (in_gap != 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (allow_idle && $urandom_range(0, 5) == 0) begin
					// start an idle burst of random length
					in_gap = $urandom_range(0, 6);
					in_valid <= 1'b0;
				end else if (frames_q.size() != 0) begin
					drv_frame = frames_q.pop_front();
					src_left     <= drv_frame.src_left;
					src_right    <= drv_frame.src_right;
					acc_left_in  <= drv_frame.acc_left;
					acc_right_in <= drv_frame.acc_right;
					run_start    <= drv_frame.run_start;
					start_phase  <= drv_frame.start_phase;
					in_valid     <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: check each transfer against the oldest prediction, stall at random
	always @(posedge clk) begin
		slot_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (mixed_q.size() == 0) begin
					$error("slot result with no mixed slot pending");
					fail_count++;
				end else begin
					want = mixed_q.pop_front();
					if (acc_left_out !== want.acc_left) begin
						$error("acc_left_out: expected %0d, actual %0d",
							want.acc_left, acc_left_out);
						fail_count++;
					end
					if (acc_right_out !== want.acc_right) begin
						$error("acc_right_out: expected %0d, actual %0d",
							want.acc_right, acc_right_out);
						fail_count++;
					end
					if (frames_advance !== want.advance) begin
						$error("frames_advance: expected %0d, actual %0d",
							want.advance, frames_advance);
						fail_count++;
					end
					n_checked++;
				end
			end
			if (out_gap != 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (allow_idle && $urandom_range(0, 5) == 0) begin
				out_gap = $urandom_range(0, 6);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: count cycles with work outstanding but no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (frames_q.size() == 0 && !in_valid && mixed_q.size() == 0)) begin
			stall_count = 0;
		end else begin
			stall_count++;
		end
		if (stall_count == STALL_LIMIT) begin
			$error("no transfer for %0d cycles with %0d slots outstanding",
				STALL_LIMIT, mixed_q.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Write one register and mirror it into the shadow copy at the same edge
	task automatic write_reg(input logic [REG_IW-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_MIX_MODE:  mix_cfg.mode          = mix_mode_t'(val[1:0]);
			REG_GAIN_L:    mix_cfg.gain_left     = val[7:0];
			REG_GAIN_R:    mix_cfg.gain_right    = val[7:0];
			REG_GAIN2_L:   mix_cfg.gain2_left    = val[7:0];
			REG_GAIN2_R:   mix_cfg.gain2_right   = val[7:0];
			REG_RATE_STEP: rate_step_r           = val;
			REG_WEIGHT_1:  mix_cfg.weight_first  = val[8:0];
			REG_WEIGHT_2:  mix_cfg.weight_second = val[8:0];
		endcase
	endtask

	// Rewrite the whole register file; call only while the block is idle
	task automatic apply_settings(input mix_mode_t mode, input logic [7:0] gl,
			input logic [7:0] gr, input logic [7:0] g2l, input logic [7:0] g2r,
			input logic [31:0] step, input logic [8:0] w1, input logic [8:0] w2);
		write_reg(REG_MIX_MODE, {30'd0, mode});
		write_reg(REG_GAIN_L, {24'd0, gl});
		write_reg(REG_GAIN_R, {24'd0, gr});
		write_reg(REG_GAIN2_L, {24'd0, g2l});
		write_reg(REG_GAIN2_R, {24'd0, g2r});
		write_reg(REG_RATE_STEP, step);
		write_reg(REG_WEIGHT_1, {23'd0, w1});
		write_reg(REG_WEIGHT_2, {23'd0, w2});
		n_settings++;
		// move off the edge before new frames are queued
		@(negedge clk);
	endtask

	// Wait until every queued frame has transferred and every slot came back
	task automatic wait_drained();
		do @(negedge clk);
		while (frames_q.size() != 0 || in_valid || mixed_q.size() != 0);
	endtask

	function automatic void queue_frame(input logic [15:0] l, input logic [15:0] r,
			input logic [31:0] al, input logic [31:0] ar, input logic st,
			input logic [31:0] ph);
		frames_q.push_back('{l, r, al, ar, st, ph});
	endfunction

	// Random picks lean on the extremes
	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'hffff;
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_acc();
		case ($urandom_range(0, 7))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [8:0] pick_weight();
		case ($urandom_range(0, 5))
			0: return 9'd0;
			1: return 9'd256;
			2: return 9'd511;
			default: return 9'($urandom_range(0, 511));
		endcase
	endfunction

	function automatic logic [31:0] pick_step();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hffff_ffff;
			2: return $urandom;
			default: return $urandom_range(0, 32'h3000_0000);
		endcase
	endfunction

	function automatic frame_t rand_frame();
		frame_t f;
		f.src_left    = pick_sample();
		f.src_right   = pick_sample();
		f.acc_left    = pick_acc();
		f.acc_right   = pick_acc();
		f.run_start   = ($urandom_range(0, 9) == 0);
		f.start_phase = $urandom;
		return f;
	endfunction

	initial begin
		int p;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Stereo: full-scale samples into accumulators at the wrap points
		apply_settings(MODE_STEREO, 8'd255, 8'd128, 8'd0, 8'd0, RATE_STEP_RST,
			WEIGHT_1_RST, 9'd0);
		queue_frame(16'h7fff, 16'h8000, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 32'h0);
		queue_frame(16'h8000, 16'h7fff, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 32'h0);
		// start phases whose integer part counts toward the first advance
		queue_frame(16'hffff, 16'h0001, 32'hffff_ffff, 32'h1, 1'b1, 32'hffff_ffff);
		queue_frame(16'h0000, 16'h0000, 32'h0, 32'h0, 1'b1, 32'h7800_0000);
		wait_drained();

		// Mono with the largest step: advance tops out at fifteen frames
		apply_settings(MODE_MONO, 8'd1, 8'd255, 8'd0, 8'd0, 32'hffff_ffff,
			WEIGHT_1_RST, 9'd0);
		queue_frame(16'h8000, 16'd12345, 32'h0, 32'h0, 1'b1, 32'h0);
		queue_frame(16'h7fff, 16'hffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 32'h0);
		queue_frame(-16'sd129, 16'h0000, 32'h0, 32'h0, 1'b0, 32'h0);
		wait_drained();

		// Doppler with a zero step: phase holds still
		apply_settings(MODE_DOPPLER, 8'd255, 8'd0, 8'd255, 8'd255, 32'd0,
			WEIGHT_1_RST, 9'd0);
		queue_frame(16'h7fff, 16'h7fff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 32'h0);
		queue_frame(16'h8000, 16'h8000, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h1234_5678);
		queue_frame(16'd100, -16'sd100, 32'h0, 32'h0, 1'b0, 32'h0);
		wait_drained();

		// Crossfade with both weights well above unity
		apply_settings(MODE_CROSS, 8'd255, 8'd255, 8'd0, 8'd0, 32'h0800_0000,
			9'd511, 9'd511);
		queue_frame(16'h7fff, 16'h7fff, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 32'h0);
		queue_frame(16'h8000, 16'h8000, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 32'h0);
		queue_frame(16'hffff, 16'hffff, 32'h0, 32'h0, 1'b0, 32'h0);
		wait_drained();

		// Crossfade that keeps only the right sample
		apply_settings(MODE_CROSS, 8'd128, 8'd255, 8'd0, 8'd0, RATE_STEP_RST,
			9'd0, 9'd256);
		queue_frame(16'h7fff, 16'h8000, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 32'h0);
		queue_frame(16'h8000, 16'h7fff, 32'h0, 32'h0, 1'b1, 32'hf000_0000);
		wait_drained();

		// Random settings, every mode in turn; drop idling for the last two phases
		for (p = 0; p < 10; p++) begin
			allow_idle = (p < 8);
			apply_settings(mix_mode_t'(p % 4), pick_gain(), pick_gain(), pick_gain(),
				pick_gain(), pick_step(), pick_weight(), pick_weight());
			repeat (48) frames_q.push_back(rand_frame());
			wait_drained();
		end

		// Let any stray result show up before closing
		repeat (8) @(posedge clk);
		$display("Mixed %0d frames, checked %0d slots over %0d register settings",
			n_frames, n_checked, n_settings);
		$display("Covered stereo, mono, doppler and crossfade with wrap and phase extremes");
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/rsm_pkg.sv
rtl/rsm_front.sv
rtl/rsm_fifo.sv
rtl/rsm_back.sv
rtl/resampling_stereo_channel_mixer_unit.sv
tb/sv/testbench.sv
